/* src/ihex_pkg.sv */
// Shared types, character codes and hex digit decode for the HEX record parser.
package ihex_pkg;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_HEADER,
        PH_PAIR_HI,
        PH_PAIR_LO,
        PH_SKIP
    } phase_t;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_ERROR = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    localparam logic [7:0]  CHAR_COLON     = 8'h3A;
    localparam logic [7:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0]  DATA_TYPE      = 8'h00;
    localparam logic [2:0]  LAST_HDR_DIGIT = 3'd7;   // eight header digits
    localparam logic [2:0]  LEN_DIGITS     = 3'd2;
    localparam logic [2:0]  ADDR_END_DIGIT = 3'd6;
    localparam logic [15:0] LINE_MAX       = 16'hFFFF;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h57);
        end
        return d;
    endfunction

endpackage

/* src/intel_hex_record_parser_unit.sv */
// Intel HEX text parser: one character per beat in, data bytes or one error out.
// Latency: a result appears on m_ side the cycle after the character beat that causes it.
// Throughput: one character beat per cycle while m_ready keeps the output register drained;
// a result still waiting on m_ready holds s_ready low, so input stalls until it is taken.
// Reset (aresetn low, synchronous): line count to 1, expecting a colon, no error,
// output register empty.
module intel_hex_record_parser_unit
    import ihex_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_char,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [16:0] m_byte_address,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_line_number
);

    // Parse state
    phase_t      phase_reg,   phase_next;
    logic [2:0]  digit_reg,   digit_next;
    logic [7:0]  length_reg,  length_next;
    logic [15:0] address_reg, address_next;
    logic [7:0]  type_reg,    type_next;
    // Only advances while below the record length, so 8 bits cover it.
    logic [7:0]  pair_reg,    pair_next;
    logic [3:0]  nibble_reg,  nibble_next;
    logic [15:0] line_reg,    line_next;
    logic        failed_reg,  failed_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg;
    logic [16:0] out_addr_reg;
    logic [7:0]  out_data_reg;
    logic [15:0] out_line_reg;

    // Result of the current beat
    logic        emit;
    logic        emit_kind;
    logic [16:0] emit_addr;
    logic [7:0]  emit_data;

    logic        accept;
    hex_digit_t  hd;
    logic        is_nl;
    logic [7:0]  pair_value;

    // Output stage can take a new result when empty or draining this cycle.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign hd      = hex_decode(s_text_char);
    assign is_nl   = (s_text_char == CHAR_NEWLINE);

    // Lone digit before a non-hex character counts as a one-digit value.
    assign pair_value = hd.valid ? {nibble_reg, hd.value} : {4'd0, nibble_reg};

    always_comb begin
        phase_next   = phase_reg;
        digit_next   = digit_reg;
        length_next  = length_reg;
        address_next = address_reg;
        type_next    = type_reg;
        pair_next    = pair_reg;
        nibble_next  = nibble_reg;
        line_next    = line_reg;
        failed_next  = failed_reg;
        emit         = 1'b0;
        emit_kind    = KIND_DATA;
        emit_addr    = 17'd0;
        emit_data    = 8'd0;

        if (accept && !failed_reg) begin
            unique case (phase_reg)
                PH_COLON: begin
                    if (s_text_char != CHAR_COLON) begin
                        emit        = 1'b1;
                        emit_kind   = KIND_ERROR;
                        failed_next = 1'b1;
                    end else begin
                        phase_next   = PH_HEADER;
                        digit_next   = 3'd0;
                        length_next  = 8'd0;
                        address_next = 16'd0;
                        type_next    = 8'd0;
                        pair_next    = 8'd0;
                    end
                end
                PH_HEADER: begin
                    if (!hd.valid) begin
                        emit        = 1'b1;
                        emit_kind   = KIND_ERROR;
                        failed_next = 1'b1;
                    end else begin
                        // Digits 0-1 length, 2-5 address, 6-7 record type.
                        if (digit_reg < LEN_DIGITS) begin
                            length_next = {length_reg[3:0], hd.value};
                        end else if (digit_reg < ADDR_END_DIGIT) begin
                            address_next = {address_reg[11:0], hd.value};
                        end else begin
                            type_next = {type_reg[3:0], hd.value};
                        end
                        if (digit_reg == LAST_HDR_DIGIT) begin
                            digit_next = 3'd0;
                            phase_next = PH_PAIR_HI;
                        end else begin
                            digit_next = digit_reg + 3'd1;
                        end
                    end
                end
                PH_PAIR_HI: begin
                    if (is_nl) begin
                        phase_next = PH_COLON;
                        if (line_reg != LINE_MAX) line_next = line_reg + 16'd1;
                    end else if (!hd.valid) begin
                        emit        = 1'b1;
                        emit_kind   = KIND_ERROR;
                        failed_next = 1'b1;
                    end else begin
                        nibble_next = hd.value;
                        phase_next  = PH_PAIR_LO;
                    end
                end
                PH_PAIR_LO: begin
                    // Checksum pair and non-data records end in skip.
                    if (type_reg != DATA_TYPE || pair_reg >= length_reg) begin
                        phase_next = PH_SKIP;
                    end else begin
                        emit       = 1'b1;
                        emit_kind  = KIND_DATA;
                        emit_addr  = {1'b0, address_reg} + {9'd0, pair_reg};
                        emit_data  = pair_value;
                        pair_next  = pair_reg + 8'd1;
                        phase_next = PH_PAIR_HI;
                    end
                    // Newline still ends the line after closing the pair.
                    if (is_nl) begin
                        phase_next = PH_COLON;
                        if (line_reg != LINE_MAX) line_next = line_reg + 16'd1;
                    end
                end
                PH_SKIP: begin
                    if (is_nl) begin
                        phase_next = PH_COLON;
                        if (line_reg != LINE_MAX) line_next = line_reg + 16'd1;
                    end
                end
                default: begin
                    phase_next = PH_COLON;
                end
            endcase
        end
    end

    always_comb begin
        if (accept) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COLON;
            digit_reg     <= 3'd0;
            length_reg    <= 8'd0;
            address_reg   <= 16'd0;
            type_reg      <= 8'd0;
            pair_reg      <= 8'd0;
            nibble_reg    <= 4'd0;
            line_reg      <= 16'd1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            digit_reg     <= digit_next;
            length_reg    <= length_next;
            address_reg   <= address_next;
            type_reg      <= type_next;
            pair_reg      <= pair_next;
            nibble_reg    <= nibble_next;
            line_reg      <= line_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; line number is the one current at the causing beat.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_kind_reg <= emit_kind;
            out_addr_reg <= emit_addr;
            out_data_reg <= emit_data;
            out_line_reg <= line_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_kind  = out_kind_reg;
    assign m_byte_address = out_addr_reg;
    assign m_data_byte    = out_data_reg;
    assign m_line_number  = out_line_reg;

endmodule
